/* rtl/blc_pkg.sv */
// Package for the burner ignition lockout controller.
// Holds the configuration, state and result types used by all RTL files, and the codes.
// Depends on nothing.
`default_nettype none

package blc_pkg;

  localparam int TEMP_W     = 11;
  localparam int READING_W  = 10;
  localparam int TIMEOUT_W  = 8;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_INDEX_W = 3;

  localparam logic [1:0] VALVE_OFF      = 2'd0;
  localparam logic [1:0] VALVE_IGNITION = 2'd1;
  localparam logic [1:0] VALVE_BURN     = 2'd2;

  localparam logic [1:0] FAULT_NONE      = 2'd0;
  localparam logic [1:0] FAULT_IGNITION  = 2'd1;
  localparam logic [1:0] FAULT_OVERHEAT  = 2'd2;
  localparam logic [1:0] FAULT_EXTINCT   = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] REG_IDEAL_TEMP       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_TEMP         = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_OVERHEAT_TEMP    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FLAME_THRESHOLD  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_IGNITION_TIMEOUT = 3'd4;

  localparam logic signed [TEMP_W-1:0] IDEAL_TEMP_RESET    = 11'sd260;
  localparam logic signed [TEMP_W-1:0] MAX_TEMP_RESET      = 11'sd280;
  localparam logic signed [TEMP_W-1:0] OVERHEAT_TEMP_RESET = 11'sd330;
  localparam logic [READING_W-1:0]     FLAME_THRESHOLD_RESET = 10'd100;
  localparam logic [TIMEOUT_W-1:0]     IGNITION_TIMEOUT_RESET = 8'd20;

  localparam logic [TIMEOUT_W-1:0] ELAPSED_MAX = 8'hFF;

  typedef struct packed {
    logic signed [TEMP_W-1:0] ideal_temp;
    logic signed [TEMP_W-1:0] max_temp;
    logic signed [TEMP_W-1:0] overheat_temp;
    logic [READING_W-1:0]     flame_threshold;
    logic [TIMEOUT_W-1:0]     ignition_timeout;
  } cfg_t;

  typedef struct packed {
    logic [1:0]           valve_mode;
    logic                 igniting;
    logic [TIMEOUT_W-1:0] ignition_elapsed;
    logic [1:0]           fault_latch;
  } state_t;

  typedef struct packed {
    logic       ignition_valve;
    logic       burn_valve;
    logic       igniter_on;
    logic [1:0] fault_code;
  } result_t;

endpackage

`default_nettype wire

/* rtl/burner_ignition_lockout_controller_unit.sv */
// Top level of the burner ignition lockout controller.
// Holds the configuration and controller state registers; uses blc_step, blc_out_buf, blc_pkg.
// Channel   Direction  Handshake                  Payload
// item      in         item_valid / item_stall    temperature, flame_reading
// result    out        result_valid / result_stall ignition_valve, burn_valve, igniter_on,
//                                                 fault_code
// cfg       in         cfg_write                  cfg_index, cfg_data
// One item is accepted per cycle while item_stall is low; its result is registered in the buffer.
// The controller state is updated by combinational logic at each accepted item.
// Two result entries are buffered; item_stall rises only when both are held.
// Reset restores the default limits, closes all valves and clears any latched fault.
`default_nettype none

module burner_ignition_lockout_controller_unit
  import blc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     item_valid,
  output logic                          item_stall,
  input  wire logic signed [TEMP_W-1:0] temperature,
  input  wire logic [READING_W-1:0]     flame_reading,
  output logic                          result_valid,
  input  wire logic                     result_stall,
  output logic                          ignition_valve,
  output logic                          burn_valve,
  output logic                          igniter_on,
  output logic [1:0]                    fault_code,
  input  wire logic                     cfg_write,
  input  wire logic [CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]    cfg_data
);

  cfg_t    cfg;
  state_t  state;
  state_t  state_next;
  result_t step_result;
  result_t out_data;
  logic    accept;
  logic    buf_full;

  assign item_stall = buf_full;
  assign accept     = item_valid && !buf_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ideal_temp       <= IDEAL_TEMP_RESET;
      cfg.max_temp         <= MAX_TEMP_RESET;
      cfg.overheat_temp    <= OVERHEAT_TEMP_RESET;
      cfg.flame_threshold  <= FLAME_THRESHOLD_RESET;
      cfg.ignition_timeout <= IGNITION_TIMEOUT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IDEAL_TEMP:       cfg.ideal_temp       <= cfg_data;
        REG_MAX_TEMP:         cfg.max_temp         <= cfg_data;
        REG_OVERHEAT_TEMP:    cfg.overheat_temp    <= cfg_data;
        REG_FLAME_THRESHOLD:  cfg.flame_threshold  <= cfg_data[READING_W-1:0];
        REG_IGNITION_TIMEOUT: cfg.ignition_timeout <= cfg_data[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.valve_mode       <= VALVE_OFF;
      state.igniting         <= 1'b0;
      state.ignition_elapsed <= '0;
      state.fault_latch      <= FAULT_NONE;
    end else if (accept) begin
      state <= state_next;
    end
  end

  blc_step u_step (
    .cfg           (cfg),
    .state         (state),
    .temperature   (temperature),
    .flame_reading (flame_reading),
    .state_next    (state_next),
    .result        (step_result)
  );

  blc_out_buf u_out_buf (
    .clk          (clk),
    .rst          (rst),
    .push         (accept),
    .push_data    (step_result),
    .full         (buf_full),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (out_data)
  );

  assign ignition_valve = out_data.ignition_valve;
  assign burn_valve     = out_data.burn_valve;
  assign igniter_on     = out_data.igniter_on;
  assign fault_code     = out_data.fault_code;

  assert property (@(posedge clk) disable iff (rst)
    (state.fault_latch != FAULT_NONE) |=> (state.fault_latch == $past(state.fault_latch)))
    else $error("A latched fault changed without reset.");

  assert property (@(posedge clk) disable iff (rst)
    (state.fault_latch != FAULT_NONE) |-> ((state.valve_mode == VALVE_OFF) && !state.igniting))
    else $error("Gas valves or igniter active while a fault is latched.");

  assert property (@(posedge clk) disable iff (rst)
    state.igniting |-> (state.valve_mode == VALVE_IGNITION))
    else $error("Ignition running without the ignition valve selected.");

endmodule

`default_nettype wire

/* rtl/blc_step.sv */
// Combinational decision logic for one control period of the burner controller.
// Computes the next controller state and the result from the current state and inputs.
// Depends on blc_pkg.
`default_nettype none

module blc_step
  import blc_pkg::*;
(
  input  wire cfg_t                     cfg,
  input  wire state_t                   state,
  input  wire logic signed [TEMP_W-1:0] temperature,
  input  wire logic [READING_W-1:0]     flame_reading,
  output state_t                        state_next,
  output result_t                       result
);

  logic flame;
  logic done;

  always_comb begin
    state_next = state;
    flame      = flame_reading > cfg.flame_threshold;
    done       = 1'b0;
    if (state.fault_latch == FAULT_NONE) begin
      if (($signed(temperature) < $signed(cfg.ideal_temp)) && !flame && !state.igniting) begin
        state_next.valve_mode       = VALVE_IGNITION;
        state_next.igniting         = 1'b1;
        state_next.ignition_elapsed = '0;
      end
      if ($signed(temperature) > $signed(cfg.overheat_temp)) begin
        state_next.fault_latch = FAULT_OVERHEAT;
        state_next.valve_mode  = VALVE_OFF;
        state_next.igniting    = 1'b0;
        done                   = 1'b1;
      end
      if (!done && ($signed(temperature) > $signed(cfg.max_temp))) begin
        state_next.valve_mode = VALVE_OFF;
        state_next.igniting   = 1'b0;
      end
      if (!done && state_next.igniting) begin
        if (flame) begin
          state_next.igniting         = 1'b0;
          state_next.valve_mode       = VALVE_BURN;
          state_next.ignition_elapsed = '0;
        end else if (state_next.ignition_elapsed >= cfg.ignition_timeout) begin
          state_next.fault_latch = FAULT_IGNITION;
          state_next.valve_mode  = VALVE_OFF;
          state_next.igniting    = 1'b0;
          done                   = 1'b1;
        end else if (state_next.ignition_elapsed != ELAPSED_MAX) begin
          state_next.ignition_elapsed = state_next.ignition_elapsed + TIMEOUT_W'(1);
        end
      end
      if (!done && !state_next.igniting && (state_next.valve_mode != VALVE_OFF) && !flame) begin
        state_next.fault_latch = FAULT_EXTINCT;
        state_next.valve_mode  = VALVE_OFF;
        state_next.igniting    = 1'b0;
      end
    end
  end

  always_comb begin
    result.fault_code = state_next.fault_latch;
    if (state_next.fault_latch != FAULT_NONE) begin
      result.ignition_valve = 1'b0;
      result.burn_valve     = 1'b0;
      result.igniter_on     = 1'b0;
    end else begin
      result.ignition_valve = state_next.valve_mode[0];
      result.burn_valve     = state_next.valve_mode[1];
      result.igniter_on     = state_next.igniting;
    end
  end

endmodule

`default_nettype wire

/* rtl/blc_out_buf.sv */
// Two-entry result buffer: an output register backed by a skid register.
// Lets the controller take a new item while an earlier result still waits. Depends on blc_pkg.
`default_nettype none

module blc_out_buf
  import blc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         full,
  output logic         result_valid,
  input  wire logic    result_stall,
  output result_t      result_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    take;

  assign take = result_valid && !result_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid) begin
      if (push) begin
        result_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else begin
      if (take && !push) begin
        result_valid <= 1'b0;
      end else if (!take && push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || (!skid_valid && take)) begin
      if (push) begin
        result_data <= push_data;
      end
    end else if (skid_valid) begin
      if (take) begin
        result_data <= skid_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  assert property (@(posedge clk) disable iff (rst) skid_valid |-> result_valid)
    else $error("Skid register holds a result while the output register is empty.");

  assert property (@(posedge clk) disable iff (rst) (skid_valid && !take) |=> skid_valid)
    else $error("Skid register lost a result that was not transferred.");

  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !take && !skid_valid && push) |=> skid_valid)
    else $error("A new result was dropped while the output register was stalled.");

endmodule

`default_nettype wire
